// File: rtl/core/mbca_pkg.sv
// shared types, constants and codes of the multi-battery charge aggregator
// used by every module of the block; depends on nothing
package mbca_pkg;

	localparam int SLOT_N   = 4;
	localparam int SLOT_W   = $clog2(SLOT_N);
	localparam int CNT_W    = 3;
	localparam int CAP_W    = 24;
	localparam int SUM_W    = CAP_W + $clog2(SLOT_N);
	localparam int ACC_W    = SUM_W + 2;
	localparam int RATE_W   = 27;
	localparam int PCT_W    = 7;
	localparam int TIME_W   = 31;
	localparam int NUM_W    = 40;
	localparam int DEN_W    = 27;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 112;

	localparam int PCT_SCALE   = 100;
	localparam int SEC_PER_HR  = 3600;
	localparam int PCT_HIGH    = 90;
	localparam int PCT_LOW     = 10;

	localparam logic FUNC_WRITE = 1'b0;

	localparam logic [1:0] REG_COUNT = 2'd0;
	localparam logic [1:0] REG_CRIT  = 2'd1;
	localparam logic [1:0] REG_LOW   = 2'd2;
	localparam logic [1:0] REG_WARN  = 2'd3;

	localparam logic [2:0] BST_DISCH    = 3'd0;
	localparam logic [2:0] BST_CHG      = 3'd1;
	localparam logic [2:0] BST_FULL     = 3'd2;
	localparam logic [2:0] BST_EMPTY    = 3'd3;
	localparam logic [2:0] BST_PEND_CHG = 3'd4;
	localparam logic [2:0] BST_PEND_DIS = 3'd5;
	localparam logic [2:0] BST_UNKNOWN  = 3'd6;

	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_WARN   = 2'd1;
	localparam logic [1:0] LVL_LOW    = 2'd2;
	localparam logic [1:0] LVL_CRIT   = 2'd3;

	localparam logic [1:0] SYS_FULL  = 2'd0;
	localparam logic [1:0] SYS_CHG   = 2'd1;
	localparam logic [1:0] SYS_EMPTY = 2'd2;
	localparam logic [1:0] SYS_DISCH = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_STORE,
		S_ACC,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_PCT,
		PH_OV,
		PH_TIME
	} phase_t;

	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic              present;
		logic [2:0]        state_bits;
		logic [CAP_W-1:0]  rem_cap;
		logic [CAP_W-1:0]  chg_now;
		logic [CAP_W-1:0]  rate_now;
		logic [CAP_W-1:0]  lfull_cap;
		logic [CAP_W-1:0]  dsgn_cap;
		logic              ac_online;
	} item_t;

	typedef struct packed {
		logic              load;
		logic              prep;
		logic              store;
		logic              acc;
		logic              emit;
		phase_t            phase;
		logic [SLOT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic need;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/mbca_div.sv
// restoring divider, one quotient bit per cycle
// depends on mbca_pkg for operand widths
module mbca_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mbca_pkg::NUM_W-1:0] num,
	input  logic [mbca_pkg::DEN_W-1:0] den,
	output logic                       done,
	output logic [mbca_pkg::NUM_W-1:0] quot
);

	logic [mbca_pkg::NUM_W-1:0]     quo_q;
	logic [mbca_pkg::DEN_W-1:0]     rem_q;
	logic [mbca_pkg::DEN_W-1:0]     den_q;
	logic [mbca_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [mbca_pkg::DEN_W:0]       shifted;
	logic                           ge;

	assign shifted = {rem_q, quo_q[mbca_pkg::NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mbca_pkg::DIV_CNT_W'(mbca_pkg::NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[mbca_pkg::NUM_W-2:0], ge};
			rem_q <= ge ? mbca_pkg::DEN_W'(shifted - {1'b0, den_q})
				: mbca_pkg::DEN_W'(shifted);
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/core/mbca_ctrl.sv
// sequencer of the aggregator: walks slots, divisions and the result hand-off
// depends on mbca_pkg for the state, phase and command types
module mbca_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mbca_pkg::status_t status,
	output mbca_pkg::cmd_t    cmd
);

	mbca_pkg::ctrl_state_t           state_q, state_d;
	mbca_pkg::phase_t                phase_q;
	logic [mbca_pkg::SLOT_W-1:0]     idx_q;
	logic                            last_idx;

	assign last_idx = idx_q == mbca_pkg::SLOT_W'(mbca_pkg::SLOT_N - 1);
	assign in_ready = state_q == mbca_pkg::S_IDLE;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbca_pkg::S_IDLE:  if (in_valid) state_d = mbca_pkg::S_PREP;
			mbca_pkg::S_PREP:  state_d = status.need ? mbca_pkg::S_DIV : mbca_pkg::S_STORE;
			mbca_pkg::S_DIV:   if (status.div_done) state_d = mbca_pkg::S_STORE;
			mbca_pkg::S_STORE: begin
				unique case (phase_q)
					mbca_pkg::PH_PCT:
						state_d = last_idx ? mbca_pkg::S_ACC : mbca_pkg::S_PREP;
					mbca_pkg::PH_OV:   state_d = mbca_pkg::S_PREP;
					mbca_pkg::PH_TIME: state_d = mbca_pkg::S_OUT;
					default:           state_d = mbca_pkg::S_OUT;
				endcase
			end
			mbca_pkg::S_ACC:   if (last_idx) state_d = mbca_pkg::S_PREP;
			mbca_pkg::S_OUT:   if (status.out_free) state_d = mbca_pkg::S_IDLE;
			default:           state_d = mbca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.phase = phase_q;
		cmd.idx   = idx_q;
		unique case (state_q)
			mbca_pkg::S_IDLE:  cmd.load  = in_valid;
			mbca_pkg::S_PREP:  cmd.prep  = 1'b1;
			mbca_pkg::S_DIV:   cmd.prep  = 1'b0;
			mbca_pkg::S_STORE: cmd.store = 1'b1;
			mbca_pkg::S_ACC:   cmd.acc   = 1'b1;
			mbca_pkg::S_OUT:   cmd.emit  = status.out_free;
			default:           cmd.load  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbca_pkg::S_IDLE;
			phase_q <= mbca_pkg::PH_PCT;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mbca_pkg::S_IDLE) begin
				phase_q <= mbca_pkg::PH_PCT;
				idx_q   <= '0;
			end else if (state_q == mbca_pkg::S_STORE) begin
				if (phase_q == mbca_pkg::PH_PCT) begin
					idx_q <= idx_q + 1'b1;
				end else if (phase_q == mbca_pkg::PH_OV) begin
					phase_q <= mbca_pkg::PH_TIME;
				end
			end else if (state_q == mbca_pkg::S_ACC) begin
				idx_q <= idx_q + 1'b1;
				if (last_idx) phase_q <= mbca_pkg::PH_OV;
			end
		end
	end

endmodule

// File: rtl/core/mbca_dp.sv
// datapath: slot records, config registers, accumulators, divider, result register
// depends on mbca_pkg and mbca_div
module mbca_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbca_pkg::cmd_t                  cmd,
	output mbca_pkg::status_t               status,
	input  mbca_pkg::item_t                 item,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_idx,
	input  logic [mbca_pkg::PCT_W-1:0]      cfg_wdata,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mbca_pkg::OUT_DATA_W-1:0] out_data
);

	localparam int N = mbca_pkg::SLOT_N;

	logic [mbca_pkg::CNT_W-1:0]  count_q;
	logic [mbca_pkg::PCT_W-1:0]  crit_q, low_q, warn_q;

	logic [N-1:0]                present_q;
	logic [2:0]                  flags_q [N];
	logic [mbca_pkg::CAP_W-1:0]  rem_q   [N];
	logic [mbca_pkg::CAP_W-1:0]  chg_q   [N];
	logic [mbca_pkg::CAP_W-1:0]  srate_q [N];
	logic [mbca_pkg::CAP_W-1:0]  fcap_q  [N];
	logic [mbca_pkg::CAP_W-1:0]  dcap_q  [N];
	logic [mbca_pkg::PCT_W-1:0]  pct_q   [N];

	logic [mbca_pkg::SLOT_W-1:0] qslot_q;
	logic                        ac_q;
	logic [mbca_pkg::SUM_W-1:0]  left_q, total_q;
	logic signed [mbca_pkg::ACC_W-1:0] rate_q;
	logic [mbca_pkg::PCT_W-1:0]  overall_q;
	logic [mbca_pkg::TIME_W-1:0] tfull_q, tempty_q;
	logic                        need_q, to_full_q;
	logic                        out_valid_q;
	logic [mbca_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [mbca_pkg::CNT_W-1:0]  eff_n;
	logic [N-1:0]                in_n;
	logic [2:0]                  st [N];
	logic                        found;
	logic [mbca_pkg::CAP_W-1:0]  cap_at;
	logic signed [mbca_pkg::RATE_W-1:0] rate_sat;
	logic                        need_c, to_full_c;
	logic [mbca_pkg::NUM_W-1:0]  num_c, quot;
	logic [mbca_pkg::DEN_W-1:0]  den_c;
	logic                        div_done;
	logic [mbca_pkg::PCT_W-1:0]  quot_pct;
	logic [mbca_pkg::TIME_W-1:0] quot_time;
	logic [1:0]                  level_c, sys_c;
	logic                        out_free;

	assign eff_n = (count_q > mbca_pkg::CNT_W'(N)) ? mbca_pkg::CNT_W'(N) : count_q;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			in_n[i] = mbca_pkg::CNT_W'(i) < eff_n;
		end
	end

	// per-slot charge state, pending taken from the first other active slot
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < N; i++) begin
			found = 1'b0;
			if (flags_q[i][0]) begin
				st[i] = mbca_pkg::BST_DISCH;
			end else if (flags_q[i][1]) begin
				st[i] = (chg_q[i] == dcap_q[i]) ? mbca_pkg::BST_FULL : mbca_pkg::BST_CHG;
			end else if (pct_q[i] > mbca_pkg::PCT_W'(mbca_pkg::PCT_HIGH)) begin
				st[i] = mbca_pkg::BST_FULL;
			end else if (pct_q[i] < mbca_pkg::PCT_W'(mbca_pkg::PCT_LOW)) begin
				st[i] = mbca_pkg::BST_EMPTY;
			end else begin
				st[i] = mbca_pkg::BST_UNKNOWN;
				for (int k = 0; k < N; k++) begin
					if (!found && k != i && in_n[k] && present_q[k] && |flags_q[k][1:0]) begin
						found = 1'b1;
						st[i] = flags_q[k][1] ? mbca_pkg::BST_PEND_CHG : mbca_pkg::BST_PEND_DIS;
					end
				end
			end
		end
	end

	assign cap_at = (fcap_q[cmd.idx] != '0) ? fcap_q[cmd.idx] : dcap_q[cmd.idx];

	always_comb begin
		if (rate_q > mbca_pkg::ACC_W'(signed'({1'b0, {(mbca_pkg::RATE_W-1){1'b1}}})))
			rate_sat = {1'b0, {(mbca_pkg::RATE_W-1){1'b1}}};
		else if (rate_q < -(mbca_pkg::ACC_W'(signed'({1'b0, 1'b1,
				{(mbca_pkg::RATE_W-1){1'b0}}}))))
			rate_sat = {1'b1, {(mbca_pkg::RATE_W-1){1'b0}}};
		else
			rate_sat = mbca_pkg::RATE_W'(rate_q);
	end

	// divider operands for the current phase
	always_comb begin
		need_c    = 1'b0;
		to_full_c = 1'b0;
		num_c     = '0;
		den_c     = '0;
		unique case (cmd.phase)
			mbca_pkg::PH_PCT: begin
				need_c = in_n[cmd.idx] && present_q[cmd.idx] && cap_at != '0;
				num_c  = mbca_pkg::NUM_W'(rem_q[cmd.idx])
					* mbca_pkg::NUM_W'(mbca_pkg::PCT_SCALE);
				den_c  = mbca_pkg::DEN_W'(cap_at);
			end
			mbca_pkg::PH_OV: begin
				need_c = total_q != '0;
				num_c  = mbca_pkg::NUM_W'(left_q) * mbca_pkg::NUM_W'(mbca_pkg::PCT_SCALE);
				den_c  = mbca_pkg::DEN_W'(total_q);
			end
			mbca_pkg::PH_TIME: begin
				if (rate_sat > 0) begin
					to_full_c = 1'b1;
					need_c    = total_q > left_q;
					num_c     = mbca_pkg::NUM_W'(total_q - left_q)
						* mbca_pkg::NUM_W'(mbca_pkg::SEC_PER_HR);
					den_c     = mbca_pkg::DEN_W'(rate_sat);
				end else if (rate_sat < 0) begin
					need_c = 1'b1;
					num_c  = mbca_pkg::NUM_W'(left_q) * mbca_pkg::NUM_W'(mbca_pkg::SEC_PER_HR);
					den_c  = mbca_pkg::DEN_W'(-rate_sat);
				end
			end
			default: need_c = 1'b0;
		endcase
	end

	mbca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.prep && need_c),
		.num    (num_c),
		.den    (den_c),
		.done   (div_done),
		.quot   (quot)
	);

	assign quot_pct = (quot > mbca_pkg::NUM_W'(mbca_pkg::PCT_SCALE))
		? mbca_pkg::PCT_W'(mbca_pkg::PCT_SCALE) : mbca_pkg::PCT_W'(quot);
	assign quot_time = (quot > mbca_pkg::NUM_W'({mbca_pkg::TIME_W{1'b1}}))
		? {mbca_pkg::TIME_W{1'b1}} : mbca_pkg::TIME_W'(quot);

	always_comb begin
		if (overall_q <= crit_q)      level_c = mbca_pkg::LVL_CRIT;
		else if (overall_q <= low_q)  level_c = mbca_pkg::LVL_LOW;
		else if (overall_q <= warn_q) level_c = mbca_pkg::LVL_WARN;
		else                          level_c = mbca_pkg::LVL_NORMAL;
		if (ac_q)
			sys_c = (overall_q > mbca_pkg::PCT_W'(mbca_pkg::PCT_HIGH) || rate_sat == 0)
				? mbca_pkg::SYS_FULL : mbca_pkg::SYS_CHG;
		else
			sys_c = (overall_q < mbca_pkg::PCT_W'(mbca_pkg::PCT_LOW))
				? mbca_pkg::SYS_EMPTY : mbca_pkg::SYS_DISCH;
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crit_q  <= mbca_pkg::PCT_W'(5);
			low_q   <= mbca_pkg::PCT_W'(10);
			warn_q  <= mbca_pkg::PCT_W'(25);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mbca_pkg::REG_COUNT: count_q <= mbca_pkg::CNT_W'(cfg_wdata);
				mbca_pkg::REG_CRIT:  crit_q  <= cfg_wdata;
				mbca_pkg::REG_LOW:   low_q   <= cfg_wdata;
				mbca_pkg::REG_WARN:  warn_q  <= cfg_wdata;
				default:             count_q <= count_q;
			endcase
		end
	end

	// slot records read as all zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int i = 0; i < N; i++) begin
				flags_q[i] <= '0;
				rem_q[i]   <= '0;
				chg_q[i]   <= '0;
				srate_q[i] <= '0;
				fcap_q[i]  <= '0;
				dcap_q[i]  <= '0;
				pct_q[i]   <= '0;
			end
		end else begin
			if (cmd.load && item.func == mbca_pkg::FUNC_WRITE) begin
				present_q[item.slot] <= item.present;
				flags_q[item.slot]   <= item.state_bits;
				rem_q[item.slot]     <= item.rem_cap;
				chg_q[item.slot]     <= item.chg_now;
				srate_q[item.slot]   <= item.rate_now;
				fcap_q[item.slot]    <= item.lfull_cap;
				dcap_q[item.slot]    <= item.dsgn_cap;
			end
			if (cmd.store && cmd.phase == mbca_pkg::PH_PCT)
				pct_q[cmd.idx] <= need_q ? quot_pct : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qslot_q  <= item.slot;
			ac_q     <= item.ac_online;
			left_q   <= '0;
			total_q  <= '0;
			rate_q   <= '0;
			tfull_q  <= '0;
			tempty_q <= '0;
		end
		if (cmd.prep) begin
			need_q    <= need_c;
			to_full_q <= to_full_c;
		end
		if (cmd.acc && in_n[cmd.idx] && present_q[cmd.idx]) begin
			left_q  <= left_q + mbca_pkg::SUM_W'(rem_q[cmd.idx]);
			total_q <= total_q + mbca_pkg::SUM_W'(cap_at);
			if (st[cmd.idx] == mbca_pkg::BST_CHG)
				rate_q <= rate_q + signed'(mbca_pkg::ACC_W'(srate_q[cmd.idx]));
			else if (st[cmd.idx] == mbca_pkg::BST_DISCH)
				rate_q <= rate_q - signed'(mbca_pkg::ACC_W'(srate_q[cmd.idx]));
		end
		if (cmd.store && cmd.phase == mbca_pkg::PH_OV)
			overall_q <= need_q ? quot_pct : '0;
		if (cmd.store && cmd.phase == mbca_pkg::PH_TIME && need_q) begin
			if (to_full_q) tfull_q  <= quot_time;
			else           tempty_q <= quot_time;
		end
		if (cmd.emit)
			out_data_q <= {2'b00, tempty_q, tfull_q, rate_sat, sys_c, level_c,
				overall_q, pct_q[qslot_q], st[qslot_q]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign status.need     = need_c;
	assign status.div_done = div_done;
	assign status.out_free = out_free;
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;

endmodule

// File: rtl/core/multi_battery_charge_aggregator_unit.sv
// four slot percents, the overall percent and the time estimate each pass through the
// shared 40-step divider (prep, waiting, store), or only prep and store when skipped;
// an accumulate pass over the four slots comes between the slot percents and the
// overall percent, and the result register is loaded last.
// throughput: one item at a time; the next item is accepted the cycle after the
// result is loaded, a result not yet taken holds back the next one. reset
// (arst_n low) clears all slot records and the registers to count 0, critical 5,
// low 10, warning 25.
module multi_battery_charge_aggregator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// slot, present, state_bits, remaining capacity, charge now, present rate,
	// last full capacity, design capacity, ac_online, zero pad
	input  logic [mbca_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// func
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// battery_state, battery_percent, overall_percent, warning_level,
	// system_state, total_rate, seconds_to_full, seconds_to_empty, zero pad
	output logic [mbca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [mbca_pkg::PCT_W-1:0]      cfg_data
);

	mbca_pkg::item_t   item;
	mbca_pkg::cmd_t    cmd;
	mbca_pkg::status_t status;

	assign item.func       = s_axis_tuser;
	assign item.slot       = s_axis_tdata[1:0];
	assign item.present    = s_axis_tdata[2];
	assign item.state_bits = s_axis_tdata[5:3];
	assign item.rem_cap    = s_axis_tdata[29:6];
	assign item.chg_now    = s_axis_tdata[53:30];
	assign item.rate_now   = s_axis_tdata[77:54];
	assign item.lfull_cap  = s_axis_tdata[101:78];
	assign item.dsgn_cap   = s_axis_tdata[125:102];
	assign item.ac_online  = s_axis_tdata[126];

	assign cfg_ready = 1'b1;

	mbca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mbca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item      (item),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// File: bench/tb.sv
// self-checking bench for the multi-battery charge aggregator unit
// predicts every report in-bench; depends on mbca_pkg and the unit's rtl
module tb;
	import mbca_pkg::*;

	localparam int WDOG_LIMIT = 20000;

	// first declared field sits in the highest bits, so this mirrors m_axis_tdata
	typedef struct packed {
		logic [30:0] tempty;
		logic [30:0] tfull;
		logic [26:0] rate;
		logic [1:0]  sys;
		logic [1:0]  level;
		logic [6:0]  overall;
		logic [6:0]  bpct;
		logic [2:0]  bstate;
	} report_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [PCT_W-1:0] cfg_data;

	multi_battery_charge_aggregator_unit DUT (.*);

	// predictor copy of slot table and registers
	logic [2:0] cnt_reg;
	logic [6:0] crit_reg, low_reg, warn_reg;
	logic       pres_q [SLOT_N];
	logic [2:0] flag_q [SLOT_N];
	logic [23:0] rem_q [SLOT_N], chg_q [SLOT_N], rt_q [SLOT_N], fc_q [SLOT_N], dc_q [SLOT_N];

	item_t   pending_items[$];
	report_t expected_reports[$];
	int  mismatches = 0;
	int  wdog = 0;
	bit  quiet_phase = 0;
	int  src_gap = 0, snk_gap = 0;

	function automatic longint slot_cap(int i);
		return (fc_q[i] != 0) ? fc_q[i] : dc_q[i];
	endfunction

	function automatic int slot_pct(int i, int n);
		longint c, p;
		if (i >= n || !pres_q[i]) return 0;
		c = slot_cap(i);
		if (c == 0) return 0;
		p = longint'(rem_q[i]) * 100 / c;
		return (p > 100) ? 100 : int'(p);
	endfunction

	function automatic logic [2:0] slot_state(int i, int n);
		int p;
		if (flag_q[i][0]) return BST_DISCH;
		if (flag_q[i][1]) return (chg_q[i] == dc_q[i]) ? BST_FULL : BST_CHG;
		p = slot_pct(i, n);
		if (p > PCT_HIGH) return BST_FULL;
		if (p < PCT_LOW) return BST_EMPTY;
		for (int k = 0; k < n; k++)
			if (k != i && pres_q[k] && flag_q[k][1:0] != 0)
				return flag_q[k][1] ? BST_PEND_CHG : BST_PEND_DIS;
		return BST_UNKNOWN;
	endfunction

	function automatic report_t charge_report(item_t it);
		report_t r;
		int n, s, ov;
		longint left, total, rate, t;
		left = 0; total = 0; rate = 0;
		if (it.func == FUNC_WRITE) begin
			pres_q[it.slot] = it.present;
			flag_q[it.slot] = it.state_bits;
			rem_q[it.slot] = it.rem_cap;
			chg_q[it.slot] = it.chg_now;
			rt_q[it.slot] = it.rate_now;
			fc_q[it.slot] = it.lfull_cap;
			dc_q[it.slot] = it.dsgn_cap;
		end
		n = (cnt_reg > SLOT_N) ? SLOT_N : int'(cnt_reg);
		for (int i = 0; i < n; i++)
			if (pres_q[i]) begin
				s = int'(slot_state(i, n));
				left += rem_q[i];
				total += slot_cap(i);
				if (s == BST_CHG) rate += rt_q[i];
				else if (s == BST_DISCH) rate -= rt_q[i];
			end
		if (rate > 67108863) rate = 67108863;
		if (rate < -67108864) rate = -67108864;
		if (total == 0) ov = 0;
		else begin
			t = left * 100 / total;
			ov = (t > 100) ? 100 : int'(t);
		end
		r.overall = 7'(ov);
		if (ov <= crit_reg) r.level = LVL_CRIT;
		else if (ov <= low_reg) r.level = LVL_LOW;
		else if (ov <= warn_reg) r.level = LVL_WARN;
		else r.level = LVL_NORMAL;
		if (it.ac_online) r.sys = (ov > PCT_HIGH || rate == 0) ? SYS_FULL : SYS_CHG;
		else r.sys = (ov < PCT_LOW) ? SYS_EMPTY : SYS_DISCH;
		r.tfull = '0;
		r.tempty = '0;
		if (rate > 0 && total > left) begin
			t = (total - left) * 3600 / rate;
			r.tfull = (t > 2147483647) ? 31'h7FFFFFFF : t[30:0];
		end
		if (rate < 0) begin
			t = left * 3600 / (-rate);
			r.tempty = (t > 2147483647) ? 31'h7FFFFFFF : t[30:0];
		end
		r.rate = rate[26:0];
		r.bstate = slot_state(int'(it.slot), n);
		r.bpct = 7'(slot_pct(int'(it.slot), n));
		return r;
	endfunction

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			src_gap <= 0;
		end else begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_items.size() > 0) begin
					item_t it;
					it = pending_items.pop_front();
					expected_reports.push_back(charge_report(it));
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= it.func;
					s_axis_tdata <= {{(IN_DATA_W-127){1'b0}}, it.ac_online, it.dsgn_cap,
						it.lfull_cap, it.rate_now, it.chg_now, it.rem_cap, it.state_bits,
						it.present, it.slot};
					if (!quiet_phase && $urandom_range(0, 5) == 0)
						src_gap <= int'($urandom_range(1, 13));
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				report_t got, exp_r;
				got = m_axis_tdata[109:0];
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected report %h", got);
				end else begin
					exp_r = expected_reports.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("report mismatch: exp st %0d pct %0d ov %0d lv %0d sys %0d rate %0d tf %0d te %0d / got st %0d pct %0d ov %0d lv %0d sys %0d rate %0d tf %0d te %0d",
								exp_r.bstate, exp_r.bpct, exp_r.overall, exp_r.level, exp_r.sys,
								$signed(exp_r.rate), exp_r.tfull, exp_r.tempty,
								got.bstate, got.bpct, got.overall, got.level, got.sys,
								$signed(got.rate), got.tfull, got.tempty);
					end
				end
			end
			if (snk_gap > 0) begin
				m_axis_tready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				snk_gap <= int'($urandom_range(0, 12));
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			wdog <= 0;
		else if (arst_n) begin
			wdog <= wdog + 1;
			if (wdog >= WDOG_LIMIT) begin
				$display("FAIL multi_battery_charge_aggregator_unit");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COUNT: cnt_reg = val[2:0];
			REG_CRIT:  crit_reg = val;
			REG_LOW:   low_reg = val;
			default:   warn_reg = val;
		endcase
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && expected_reports.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_cap();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom_range(0, 255));
			3: return 24'($urandom_range(0, 20000));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		logic [23:0] c;
		it.func = ($urandom_range(0, 3) == 0);
		it.slot = 2'($urandom_range(0, 3));
		it.present = ($urandom_range(0, 4) != 0);
		it.state_bits = 3'($urandom_range(0, 7));
		c = rand_cap();
		it.lfull_cap = ($urandom_range(0, 3) == 0) ? 24'd0 : c;
		it.dsgn_cap = ($urandom_range(0, 1) != 0) ? c : rand_cap();
		if (c != 0 && $urandom_range(0, 2) != 0)
			it.rem_cap = 24'(longint'(c) * longint'($urandom_range(0, 105)) / 100);
		else
			it.rem_cap = rand_cap();
		it.chg_now = ($urandom_range(0, 2) == 0) ? it.dsgn_cap : rand_cap();
		it.rate_now = rand_cap();
		it.ac_online = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t mk(logic f, logic [1:0] s, logic p, logic [2:0] b,
		logic [23:0] rem, logic [23:0] ch, logic [23:0] rt, logic [23:0] fc,
		logic [23:0] dc, logic ac);
		item_t it;
		it.func = f; it.slot = s; it.present = p; it.state_bits = b;
		it.rem_cap = rem; it.chg_now = ch; it.rate_now = rt;
		it.lfull_cap = fc; it.dsgn_cap = dc; it.ac_online = ac;
		return it;
	endfunction

	initial begin
		cnt_reg = 0; crit_reg = 5; low_reg = 10; warn_reg = 25;
		for (int i = 0; i < SLOT_N; i++) begin
			pres_q[i] = 0; flag_q[i] = 0; rem_q[i] = 0; chg_q[i] = 0;
			rt_q[i] = 0; fc_q[i] = 0; dc_q[i] = 0;
		end
		cfg_valid = 1'b0;
		cfg_index = REG_COUNT;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset values with no capacity, then the directed cases
		pending_items.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();
		write_reg(REG_COUNT, 7'd4);
		pending_items.push_back(mk(0, 0, 1, 3'b010, 500, 1000, 100, 0, 1000, 1));
		pending_items.push_back(mk(0, 1, 1, 3'b001, 800, 900, 200, 1000, 1200, 0));
		pending_items.push_back(mk(0, 2, 1, 3'b000, 500, 0, 0, 1000, 1000, 0));
		pending_items.push_back(mk(0, 0, 1, 3'b010, 1000, 1000, 10, 0, 1000, 1));
		pending_items.push_back(mk(0, 3, 1, 3'b000, 950, 0, 0, 1000, 0, 1));
		pending_items.push_back(mk(0, 3, 1, 3'b100, 50, 0, 0, 1000, 0, 0));
		pending_items.push_back(mk(0, 3, 1, 3'b011, 24'hFFFFFF, 0, 24'hFFFFFF,
			24'h1, 24'hFFFFFF, 1));
		pending_items.push_back(mk(0, 0, 1, 3'b001, 24'hFFFFFF, 0, 24'h1, 24'hFFFFFF,
			24'hFFFFFF, 0));
		pending_items.push_back(mk(0, 1, 1, 3'b001, 24'hFFFFFF, 0, 24'hFFFFFF,
			24'hFFFFFF, 0, 0));
		pending_items.push_back(mk(0, 2, 1, 3'b001, 24'hFFFFFF, 0, 24'hFFFFFF, 0,
			24'hFFFFFF, 0));
		pending_items.push_back(mk(0, 3, 1, 3'b001, 24'hFFFFFF, 0, 24'hFFFFFF, 0,
			24'hFFFFFF, 0));
		pending_items.push_back(mk(0, 0, 1, 3'b010, 1, 5, 24'hFFFFFF, 0, 24'hFFFFFF, 1));
		pending_items.push_back(mk(0, 1, 1, 3'b010, 2, 5, 24'hFFFFFF, 0, 24'hFFFFFF, 1));
		pending_items.push_back(mk(0, 2, 1, 3'b010, 0, 5, 24'hFFFFFF, 0, 24'hFFFFFF, 1));
		pending_items.push_back(mk(0, 3, 0, 3'b111, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(1, 3, 0, 0, 0, 0, 0, 0, 0, 1));
		pending_items.push_back(mk(0, 2, 1, 3'b000, 600, 0, 0, 0, 1000, 0));
		pending_items.push_back(mk(0, 1, 0, 3'b000, 0, 0, 0, 0, 0, 0));
		drain();
		write_reg(REG_COUNT, 7'd7);
		write_reg(REG_CRIT, 7'd0);
		write_reg(REG_LOW, 7'd100);
		write_reg(REG_WARN, 7'd127);
		pending_items.push_back(mk(1, 2, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(mk(1, 1, 0, 0, 0, 0, 0, 0, 0, 1));
		drain();

		// random phases under different settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_COUNT, (ph == 0) ? 7'd0 : (ph == 7) ? 7'd4
				: 7'($urandom_range(0, 7)));
			write_reg(REG_CRIT, (ph == 1) ? 7'd100 : 7'($urandom_range(0, 30)));
			write_reg(REG_LOW, (ph == 2) ? 7'd0 : 7'($urandom_range(0, 60)));
			write_reg(REG_WARN, (ph == 3) ? 7'd127 : 7'($urandom_range(0, 100)));
			if (ph == 7) quiet_phase = 1;
			for (int k = 0; k < 135; k++)
				pending_items.push_back(rand_item());
			drain();
		end
		if (mismatches == 0)
			$display("PASS multi_battery_charge_aggregator_unit");
		else
			$display("FAIL multi_battery_charge_aggregator_unit");
		$finish;
	end
endmodule

// File: multi_battery_charge_aggregator_unit.f
rtl/core/mbca_pkg.sv
rtl/core/mbca_div.sv
rtl/core/mbca_ctrl.sv
rtl/core/mbca_dp.sv
rtl/core/multi_battery_charge_aggregator_unit.sv
bench/tb.sv
